@@ src/rycc_pkg.sv @@
// ----------------------------------------------------------------------------
// rycc_pkg: shared types and constants for the RGB/YCbCr color converter
// Pixel word layouts, conversion direction codes and fixed-point defaults.
// ----------------------------------------------------------------------------
package rycc_pkg;

  // Default number of fraction bits in the coefficients
  localparam int FRAC_BITS_DEF = 16;

  // Component width and signed operand width (component minus chroma offset)
  localparam int COMP_W = 8;
  localparam int OPND_W = COMP_W + 1;

  // Chroma offset as a signed operand
  localparam logic signed [OPND_W-1:0] CHROMA_OFS = 9'sd128;

  // Largest component value
  localparam logic [COMP_W-1:0] COMP_MAX = 8'd255;

  // Conversion direction
  typedef enum logic [0:0] {
    DIR_RGB_TO_YCC = 1'b0,
    DIR_YCC_TO_RGB = 1'b1
  } dir_e;

  // Input pixel word
  typedef struct packed {
    logic [COMP_W-1:0] in_red_or_cr;
    logic [COMP_W-1:0] in_green_or_luma;
    logic [COMP_W-1:0] in_blue_or_cb;
  } pix_in_t;

  // Output pixel word
  typedef struct packed {
    logic [COMP_W-1:0] out_red_or_cr;
    logic [COMP_W-1:0] out_green_or_luma;
    logic [COMP_W-1:0] out_blue_or_cb;
    logic              clipped;
  } pix_out_t;

endpackage

@@ src/rycc_mul.sv @@
// ----------------------------------------------------------------------------
// rycc_mul: operand and product stage
// Forms signed operands, selects the coefficient matrix for the direction
// and registers the nine coefficient products.
// ----------------------------------------------------------------------------
module rycc_mul #(
  parameter int  FRAC_BITS = rycc_pkg::FRAC_BITS_DEF,
  localparam int CW        = FRAC_BITS + 2,
  localparam int PW        = CW + rycc_pkg::OPND_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rycc_pkg::pix_in_t    pix_i,
  input  rycc_pkg::dir_e       dir_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [PW-1:0] prod_o [3][3],
  output rycc_pkg::dir_e       dir_o
);

  // Coefficients, rounded half up to FRAC_BITS fraction bits
  localparam longint K_ONE  = longint'(1) << FRAC_BITS;
  localparam longint K_YR   = ((longint'(299) << FRAC_BITS) + 500) / 1000;
  localparam longint K_YG   = ((longint'(587) << FRAC_BITS) + 500) / 1000;
  localparam longint K_YB   = ((longint'(114) << FRAC_BITS) + 500) / 1000;
  localparam longint K_BR   = ((longint'(1687) << FRAC_BITS) + 5000) / 10000;
  localparam longint K_BG   = ((longint'(3313) << FRAC_BITS) + 5000) / 10000;
  localparam longint K_HALF = ((longint'(1) << FRAC_BITS) + 1) / 2;
  localparam longint K_RG   = ((longint'(4187) << FRAC_BITS) + 5000) / 10000;
  localparam longint K_RB   = ((longint'(813) << FRAC_BITS) + 5000) / 10000;
  localparam longint K_CR_R = ((longint'(1402) << FRAC_BITS) + 500) / 1000;
  localparam longint K_CB_G = ((longint'(34414) << FRAC_BITS) + 50000) / 100000;
  localparam longint K_CR_G = ((longint'(71414) << FRAC_BITS) + 50000) / 100000;
  localparam longint K_CB_B = ((longint'(1772) << FRAC_BITS) + 500) / 1000;

  logic signed [rycc_pkg::OPND_W-1:0] opnd [3];
  logic signed [CW-1:0]               coef [3][3];
  logic signed [PW-1:0]               prod_d [3][3];
  logic signed [PW-1:0]               prod_q [3][3];
  logic                               valid_q;
  rycc_pkg::dir_e                     dir_q;

  // Operands: chroma loses its offset in the reverse direction
  always_comb begin
    opnd[0] = signed'({1'b0, pix_i.in_red_or_cr});
    opnd[1] = signed'({1'b0, pix_i.in_green_or_luma});
    opnd[2] = signed'({1'b0, pix_i.in_blue_or_cb});
    if (dir_i == rycc_pkg::DIR_YCC_TO_RGB) begin
      opnd[0] = opnd[0] - rycc_pkg::CHROMA_OFS;
      opnd[2] = opnd[2] - rycc_pkg::CHROMA_OFS;
    end
  end

  // Coefficient matrix; rows are the output components, columns the inputs
  always_comb begin
    case (dir_i)
      rycc_pkg::DIR_YCC_TO_RGB: begin
        coef[0][0] = CW'(K_CR_R);
        coef[0][1] = CW'(K_ONE);
        coef[0][2] = '0;
        coef[1][0] = CW'(-K_CR_G);
        coef[1][1] = CW'(K_ONE);
        coef[1][2] = CW'(-K_CB_G);
        coef[2][0] = '0;
        coef[2][1] = CW'(K_ONE);
        coef[2][2] = CW'(K_CB_B);
      end
      default: begin
        coef[0][0] = CW'(K_HALF);
        coef[0][1] = CW'(-K_RG);
        coef[0][2] = CW'(-K_RB);
        coef[1][0] = CW'(K_YR);
        coef[1][1] = CW'(K_YG);
        coef[1][2] = CW'(K_YB);
        coef[2][0] = CW'(-K_BR);
        coef[2][1] = CW'(-K_BG);
        coef[2][2] = CW'(K_HALF);
      end
    endcase
  end

  // Nine products, each a narrow signed multiply
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = coef[r][c] * opnd[c];
      end
    end
  end

  // Stage handshake: take a word when empty or when the word here moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
      dir_q  <= dir_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign dir_o   = dir_q;

endmodule

@@ src/rycc_sum.sv @@
// ----------------------------------------------------------------------------
// rycc_sum: accumulation stage
// Adds the three products of each row and the chroma offset where the
// forward direction needs it; registers the fixed-point sums.
// ----------------------------------------------------------------------------
module rycc_sum #(
  parameter int  FRAC_BITS = rycc_pkg::FRAC_BITS_DEF,
  localparam int PW        = FRAC_BITS + 2 + rycc_pkg::OPND_W,
  localparam int SW        = PW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [PW-1:0] prod_i [3][3],
  input  rycc_pkg::dir_e       dir_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [SW-1:0] sum_o [3]
);

  // 128 in fixed point
  localparam logic signed [SW-1:0] OFS_FIX = SW'(longint'(128) << FRAC_BITS);

  logic signed [SW-1:0] bias [3];
  logic signed [SW-1:0] sum_d [3];
  logic signed [SW-1:0] sum_q [3];
  logic                 valid_q;

  // Chroma rows (Cr, Cb) get the offset in the forward direction only
  always_comb begin
    bias[0] = '0;
    bias[1] = '0;
    bias[2] = '0;
    if (dir_i == rycc_pkg::DIR_RGB_TO_YCC) begin
      bias[0] = OFS_FIX;
      bias[2] = OFS_FIX;
    end
  end

  // Row sums, exact
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SW'(prod_i[r][0]) + SW'(prod_i[r][1]) + SW'(prod_i[r][2]) + bias[r];
    end
  end

  // Stage handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

@@ src/rycc_sat.sv @@
// ----------------------------------------------------------------------------
// rycc_sat: floor and saturation stage
// Drops the fraction (floor), clamps each component to 0..255, flags any
// clamp and holds the result in the output register.
// ----------------------------------------------------------------------------
module rycc_sat #(
  parameter int  FRAC_BITS = rycc_pkg::FRAC_BITS_DEF,
  localparam int SW        = FRAC_BITS + 4 + rycc_pkg::OPND_W,
  localparam int QW        = SW - FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [SW-1:0] sum_i [3],
  output logic                 valid_o,
  input  logic                 ready_i,
  output rycc_pkg::pix_out_t   pix_o
);

  logic signed [QW-1:0]              quot [3];
  logic [rycc_pkg::COMP_W-1:0]       comp [3];
  logic [2:0]                        clip;
  rycc_pkg::pix_out_t                pix_d;
  rycc_pkg::pix_out_t                pix_q;
  logic                              valid_q;

  // Integer part of a two's complement sum is its floor
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      quot[r] = signed'(sum_i[r][SW-1:FRAC_BITS]);
      if (quot[r][QW-1]) begin
        comp[r] = '0;
        clip[r] = 1'b1;
      end else if (|quot[r][QW-2:rycc_pkg::COMP_W]) begin
        comp[r] = rycc_pkg::COMP_MAX;
        clip[r] = 1'b1;
      end else begin
        comp[r] = quot[r][rycc_pkg::COMP_W-1:0];
        clip[r] = 1'b0;
      end
    end
  end

  always_comb begin
    pix_d.out_red_or_cr     = comp[0];
    pix_d.out_green_or_luma = comp[1];
    pix_d.out_blue_or_cb    = comp[2];
    pix_d.clipped           = |clip;
  end

  // Output register handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

@@ src/rgb_ycbcr_color_convert.sv @@
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_convert: JFIF RGB <-> full-range YCbCr converter
// One 8-bit three-component pixel in, one converted pixel out, with a
// direction register and saturation to 0..255.
// ----------------------------------------------------------------------------
//
//   channel | signals                                | word
//   --------+----------------------------------------+---------------------
//   in      | in_valid_i  in_ready_o  in_data_i      | pix_in_t
//   out     | out_valid_o out_ready_i out_data_o     | pix_out_t
//   cfg     | cfg_valid_i cfg_ready_o cfg_direction_i| direction, 1 bit
//
// One word per cycle while the output is not stalled; an accepted word passes
// through the input, product, sum and output registers, in that order.
// Reset clears every valid bit and sets the direction to RGB -> YCbCr.
// Ready runs back through the stages, so a stalled output fills the empty
// stages first and then holds the input off; no word is dropped or doubled.
// Each word carries the direction it was accepted with.
//
module rgb_ycbcr_color_convert #(
  parameter int FRAC_BITS = rycc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rycc_pkg::pix_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rycc_pkg::pix_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_direction_i
);

  localparam int PW = FRAC_BITS + 2 + rycc_pkg::OPND_W;
  localparam int SW = PW + 2;

  rycc_pkg::dir_e       dir_q;
  logic                 in_valid_q;
  rycc_pkg::pix_in_t    in_pix_q;
  rycc_pkg::dir_e       in_dir_q;

  logic                 mul_ready;
  logic                 mul_valid;
  logic signed [PW-1:0] mul_prod [3][3];
  rycc_pkg::dir_e       mul_dir;

  logic                 sum_ready;
  logic                 sum_valid;
  logic signed [SW-1:0] sum_val [3];

  logic                 sat_ready;

  // Direction register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= rycc_pkg::DIR_RGB_TO_YCC;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dir_q <= rycc_pkg::dir_e'(cfg_direction_i);
    end
  end

  // Input register
  assign in_ready_o = !in_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_pix_q <= in_data_i;
      in_dir_q <= dir_q;
    end
  end

  // Products
  rycc_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (mul_ready),
    .pix_i   (in_pix_q),
    .dir_i   (in_dir_q),
    .valid_o (mul_valid),
    .ready_i (sum_ready),
    .prod_o  (mul_prod),
    .dir_o   (mul_dir)
  );

  // Row sums
  rycc_sum #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (sum_ready),
    .prod_i  (mul_prod),
    .dir_i   (mul_dir),
    .valid_o (sum_valid),
    .ready_i (sat_ready),
    .sum_o   (sum_val)
  );

  // Floor, saturate, output register
  rycc_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sat_ready),
    .sum_i   (sum_val),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .pix_o   (out_data_o)
  );

`ifndef SYNTHESIS
  // An empty output register means every stage can take a word
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input held off with an empty pipeline");

  // A clipped word has at least one component at a rail
  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      (out_data_o.out_red_or_cr == '0) || (out_data_o.out_red_or_cr == '1) ||
      (out_data_o.out_green_or_luma == '0) || (out_data_o.out_green_or_luma == '1) ||
      (out_data_o.out_blue_or_cb == '0) || (out_data_o.out_blue_or_cb == '1))
    else $error("clip flag set with no saturated component");

  // A stalled output stops the stage ahead of it from taking a new word
  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !sat_ready)
    else $error("output register accepts while stalled");
`endif

endmodule
